### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("lbl");
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/cid_pkg.sv
// ---------------------------------------------------------------------------
// cid_pkg
// Types, constants and helpers of the circle distance core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package cid_pkg;
    localparam int MAX_CIRCLES = 16;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 5;
    localparam int INDEX_WIDTH = 12;
    localparam int ROOT_STEPS  = 32;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_SPACING_X = 3'd2;
    localparam logic [2:0] REG_SPACING_Y = 3'd3;
    localparam logic [2:0] REG_COUNT     = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PX, ST_PY, ST_PYF, ST_DIFF, ST_SQX, ST_SQY, ST_SUM,
        ST_ROOT, ST_ACC, ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

    typedef struct packed {
        logic              sat;
        logic signed [31:0] val;
    } t_clip;

    function automatic t_clip clip32(input logic signed [45:0] v);
        t_clip c;
        c.sat = 1'b0;
        c.val = v[31:0];
        if (v > 46'sd2147483647) begin
            c.sat = 1'b1;
            c.val = Q_MAX;
        end else if (v < -46'sd2147483648) begin
            c.sat = 1'b1;
            c.val = Q_MIN;
        end
        return c;
    endfunction
endpackage

### rtl/cid_root.sv
// ---------------------------------------------------------------------------
// cid_root
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module cid_root (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [63:0]         i_value,
    output cid_pkg::t_root_stat o_stat,
    output logic [31:0]         o_root
);
    logic [63:0] r_v, r_r, r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] w_trial;

    assign w_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'(cid_pkg::ROOT_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(cid_pkg::ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v <= r_v - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_r[31:0];
endmodule

### rtl/circle_intersection_distance_core.sv
// ---------------------------------------------------------------------------
// circle_intersection_distance_core
// Signed distance to a union of up to sixteen circles at a grid point.
// ---------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser
// s       | in  | entry_index,cx,cy,radius,inside,col,row | cmd
// m       | out | distance                                | saturated
// cfg     | in  | write enable, index, 32-bit data        | -
//
// A load is written when taken and the block stays ready. An evaluation
// steps PX, PY, PYF, then DIFF, SQX, SQY, SUM, ROOT, ACC per circle, then
// DONE, then IDLE takes the next item; the 32-step square root dominates.
// One shared 32x32 multiplier forms both grid products and both squares.
// Reset is synchronous; tables hold garbage until loaded.
// A finished result waits in the output register; the next item is taken
// meanwhile, but a later result holds until that one is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module circle_intersection_distance_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // entry_index[3:0] cx[35:4] cy[67:36] radius[99:68] inside[100]
    // column[112:101] row[124:113]
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tuser,   // cmd
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,   // distance
    output logic         o_m_tuser    // saturated
);
    localparam int MC = cid_pkg::MAX_CIRCLES;

    logic signed [31:0] r_org_x, r_org_y;
    logic [30:0] r_sp_x, r_sp_y;
    logic [cid_pkg::CNT_W-1:0] r_count;

    logic signed [31:0] r_cx [MC];
    logic signed [31:0] r_cy [MC];
    logic signed [31:0] r_rad [MC];
    logic               r_ins [MC];

    cid_pkg::t_state r_state, n_state;
    logic [cid_pkg::INDEX_WIDTH-1:0] r_col, r_row;
    logic [63:0] r_prod, r_sum;
    logic [31:0] r_ax, r_ay;
    logic signed [31:0] r_px, r_py, r_best;
    logic r_sat;
    logic [cid_pkg::CNT_W-1:0] r_k, w_n;
    logic r_out_valid, r_out_sat;
    logic signed [31:0] r_out;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mul;
    logic w_accept, w_root_start;
    cid_pkg::t_root_stat w_rstat;
    logic [31:0] w_root;
    cid_pkg::t_clip w_cpx, w_cpy, w_cdx, w_cdy, w_cd;
    logic signed [34:0] w_d;
    logic [cid_pkg::SLOT_W-1:0] w_slot, w_kk;

    assign w_n = (r_count > cid_pkg::CNT_W'(MC)) ? cid_pkg::CNT_W'(MC) : r_count;
    assign w_kk = r_k[cid_pkg::SLOT_W-1:0];
    assign w_slot = i_s_tdata[3:0];

    assign o_s_tready = (r_state == cid_pkg::ST_IDLE);
    assign w_accept = i_s_tvalid && o_s_tready;

    // shared multiplier
    always_comb begin
        w_ma = r_ax;
        w_mb = r_ax;
        unique case (r_state)
            cid_pkg::ST_PX: begin
                w_ma = {1'b0, r_sp_x};
                w_mb = 32'(r_col);
            end
            cid_pkg::ST_PY: begin
                w_ma = {1'b0, r_sp_y};
                w_mb = 32'(r_row);
            end
            cid_pkg::ST_SQY: begin
                w_ma = r_ay;
                w_mb = r_ay;
            end
            default: begin
                w_ma = r_ax;
                w_mb = r_ax;
            end
        endcase
    end
    assign w_mul = 64'(w_ma) * 64'(w_mb);

    assign w_cpx = cid_pkg::clip32(46'(r_org_x) + $signed({3'b000, r_prod[42:0]}));
    assign w_cpy = cid_pkg::clip32(46'(r_org_y) + $signed({3'b000, r_prod[42:0]}));
    assign w_cdx = cid_pkg::clip32(46'(r_px) - 46'(r_cx[w_kk]));
    assign w_cdy = cid_pkg::clip32(46'(r_py) - 46'(r_cy[w_kk]));
    assign w_d   = $signed({3'b000, w_root}) - 35'(r_rad[w_kk]);
    assign w_cd  = cid_pkg::clip32(r_ins[w_kk] ? -46'(w_d) : 46'(w_d));
    assign w_root_start = (r_state == cid_pkg::ST_SUM);

    cid_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_sum + r_prod),
        .o_stat  (w_rstat),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cid_pkg::ST_IDLE:
                if (w_accept && i_s_tuser == cid_pkg::CMD_EVAL) n_state = cid_pkg::ST_PX;
            cid_pkg::ST_PX:  n_state = cid_pkg::ST_PY;
            cid_pkg::ST_PY:  n_state = cid_pkg::ST_PYF;
            cid_pkg::ST_PYF: n_state = (w_n == '0) ? cid_pkg::ST_DONE : cid_pkg::ST_DIFF;
            cid_pkg::ST_DIFF: n_state = cid_pkg::ST_SQX;
            cid_pkg::ST_SQX: n_state = cid_pkg::ST_SQY;
            cid_pkg::ST_SQY: n_state = cid_pkg::ST_SUM;
            cid_pkg::ST_SUM: n_state = cid_pkg::ST_ROOT;
            cid_pkg::ST_ROOT: if (w_rstat.done) n_state = cid_pkg::ST_ACC;
            cid_pkg::ST_ACC:
                n_state = (r_k + 1'b1 == w_n) ? cid_pkg::ST_DONE : cid_pkg::ST_DIFF;
            cid_pkg::ST_DONE:
                if (!r_out_valid || i_m_tready) n_state = cid_pkg::ST_IDLE;
            default: n_state = cid_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cid_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_sp_x      <= 31'd65536;
            r_sp_y      <= 31'd65536;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cid_pkg::REG_ORIGIN_X:  r_org_x <= i_cfg_data;
                    cid_pkg::REG_ORIGIN_Y:  r_org_y <= i_cfg_data;
                    cid_pkg::REG_SPACING_X: r_sp_x  <= i_cfg_data[30:0];
                    cid_pkg::REG_SPACING_Y: r_sp_y  <= i_cfg_data[30:0];
                    cid_pkg::REG_COUNT:     r_count <= i_cfg_data[cid_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == cid_pkg::ST_DONE && (!r_out_valid || i_m_tready))
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_tuser == cid_pkg::CMD_LOAD
            && 32'(w_slot) < 32'(MC)) begin
            r_cx[w_slot]  <= i_s_tdata[35:4];
            r_cy[w_slot]  <= i_s_tdata[67:36];
            r_rad[w_slot] <= i_s_tdata[99:68];
            r_ins[w_slot] <= i_s_tdata[100];
        end
        if (w_accept) begin
            r_col <= i_s_tdata[112:101];
            r_row <= i_s_tdata[124:113];
        end
        unique case (r_state)
            cid_pkg::ST_PX: begin
                r_prod <= w_mul;
                r_sat  <= 1'b0;
                r_best <= cid_pkg::Q_MIN;
                r_k    <= '0;
            end
            cid_pkg::ST_PY: begin
                r_px   <= w_cpx.val;
                r_sat  <= r_sat | w_cpx.sat;
                r_prod <= w_mul;
            end
            cid_pkg::ST_PYF: begin
                r_py  <= w_cpy.val;
                r_sat <= r_sat | w_cpy.sat;
            end
            cid_pkg::ST_DIFF: begin
                // magnitudes fit 32 bits unsigned, including the most negative value
                r_ax  <= w_cdx.val[31] ? 32'(-w_cdx.val) : w_cdx.val;
                r_ay  <= w_cdy.val[31] ? 32'(-w_cdy.val) : w_cdy.val;
                r_sat <= r_sat | w_cdx.sat | w_cdy.sat;
            end
            cid_pkg::ST_SQX: r_prod <= w_mul;
            cid_pkg::ST_SQY: begin
                r_sum  <= r_prod;
                r_prod <= w_mul;
            end
            cid_pkg::ST_ACC: begin
                r_sat <= r_sat | w_cd.sat;
                if (w_cd.val > r_best) r_best <= w_cd.val;
                r_k <= r_k + 1'b1;
            end
            cid_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    r_out     <= r_best;
                    r_out_sat <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_out_sat;

    `ASSERT_CLKD(a_root_only_in_root, i_clk, i_rst_n, w_rstat.busy |-> r_state == cid_pkg::ST_ROOT)
    `ASSERT_CLKD(a_done_ends_root, i_clk, i_rst_n, w_rstat.done |-> r_state == cid_pkg::ST_ROOT)
    `ASSERT_NEVER(a_k_in_range, i_clk, i_rst_n, r_state == cid_pkg::ST_ACC && r_k >= w_n)
    `ASSERT_CLKD(a_out_kept, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid)
endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// Circle distance core testbench
// Loads circle tables, sweeps grid settings and evaluates points. Each
// result is checked against a local signed distance predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic signed [31:0] dval;
        logic               sat;
    } t_distance;

    class distance_board;
        logic signed [31:0] org_x, org_y;
        logic [30:0]        step_x, step_y;
        logic [4:0]         count;
        logic signed [31:0] cx_tab [cid_pkg::MAX_CIRCLES];
        logic signed [31:0] cy_tab [cid_pkg::MAX_CIRCLES];
        logic signed [31:0] rad_tab [cid_pkg::MAX_CIRCLES];
        logic               in_tab [cid_pkg::MAX_CIRCLES];
        t_distance          pending[$];
        int                 errors;

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                cid_pkg::REG_ORIGIN_X:  org_x = data;
                cid_pkg::REG_ORIGIN_Y:  org_y = data;
                cid_pkg::REG_SPACING_X: step_x = data[30:0];
                cid_pkg::REG_SPACING_Y: step_y = data[30:0];
                cid_pkg::REG_COUNT:     count = data[4:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, ref logic flag);
            if (v > 64'sd2147483647) begin
                flag = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                flag = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // floor square root, one result bit per step from the top
        function longint floor_root(bit [63:0] v);
            bit [63:0] r, trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= v) r = trial;
            end
            return longint'(r);
        endfunction

        function void note_item(logic cmd, logic [124:0] data);
            logic [3:0]  slot;
            logic        flag;
            longint      px, py, dx, dy, d, best;
            bit [63:0]   sq;
            int          n;
            t_distance   e;
            slot = data[3:0];
            if (cmd == cid_pkg::CMD_LOAD) begin
                cx_tab[slot]  = data[35:4];
                cy_tab[slot]  = data[67:36];
                rad_tab[slot] = data[99:68];
                in_tab[slot]  = data[100];
                return;
            end
            flag = 1'b0;
            px = clamp(longint'(org_x) + longint'(step_x) * longint'(data[112:101]), flag);
            py = clamp(longint'(org_y) + longint'(step_y) * longint'(data[124:113]), flag);
            n = (count > cid_pkg::MAX_CIRCLES) ? cid_pkg::MAX_CIRCLES : count;
            best = -64'sd2147483648;
            for (int k = 0; k < n; k++) begin
                dx = clamp(px - longint'(cx_tab[k]), flag);
                dy = clamp(py - longint'(cy_tab[k]), flag);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = $unsigned(dx) * $unsigned(dx) + $unsigned(dy) * $unsigned(dy);
                d = floor_root(sq) - longint'(rad_tab[k]);
                if (in_tab[k]) d = -d;
                d = clamp(d, flag);
                if (d > best) best = d;
            end
            e.dval = best[31:0];
            e.sat  = flag;
            pending.push_back(e);
        endfunction

        function void check_result(logic [31:0] got_val, logic sat);
            t_distance e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result dist=%h sat=%b", got_val, sat);
                return;
            end
            e = pending.pop_front();
            if (got_val !== e.dval || sat !== e.sat) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch dist exp=%h got=%h sat exp=%b got=%b",
                             e.dval, got_val, e.sat, sat);
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;
    logic         i_s_tvalid, o_s_tready;
    logic [127:0] i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid, i_m_tready;
    logic [31:0]  o_m_tdata;
    logic         o_m_tuser;

    distance_board board;
    bit            calm;
    int            hold_left;

    circle_intersection_distance_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_item(i_s_tuser, i_s_tdata[124:0]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata, o_m_tuser);
    end

    // receiver: random stalls, or a long hold-off when requested
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = calm || ($urandom_range(99) >= 34);
            end
        end
    end

    function automatic logic [31:0] pick_q();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(40 << 16)) - (20 << 16));
            3: return 32'(int'($urandom_range(400 << 16)));
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send(logic cmd, logic [3:0] slot, logic [31:0] cx, logic [31:0] cy,
                        logic [31:0] rad, logic ins, logic [11:0] col, logic [11:0] row);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 34) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {3'b0, row, col, ins, rad, cy, cx, slot};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic load(logic [3:0] slot, logic [31:0] cx, logic [31:0] cy,
                        logic [31:0] rad, logic ins);
        send(cid_pkg::CMD_LOAD, slot, cx, cy, rad, ins, 12'($urandom()), 12'($urandom()));
    endtask

    task automatic evaluate(logic [11:0] col, logic [11:0] row);
        send(cid_pkg::CMD_EVAL, 4'($urandom()), $urandom(), $urandom(), $urandom(),
             1'($urandom()), col, row);
    endtask

    // drop valid and let the block drain before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] sx, sy;
        int          cnt;
        board      = new();
        board.set_reg(cid_pkg::REG_ORIGIN_X, 0);
        board.set_reg(cid_pkg::REG_ORIGIN_Y, 0);
        board.set_reg(cid_pkg::REG_SPACING_X, 32'd65536);
        board.set_reg(cid_pkg::REG_SPACING_Y, 32'd65536);
        board.set_reg(cid_pkg::REG_COUNT, 0);
        calm       = 1'b0;
        hold_left  = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = cid_pkg::REG_ORIGIN_X;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = cid_pkg::CMD_LOAD;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // no circles yet
        evaluate(12'd0, 12'd0);
        evaluate(12'hFFF, 12'hFFF);
        load(4'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        load(4'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        load(4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        load(4'd3, 32'h0005_0000, 32'h0003_0000, 32'h0002_0000, 1'b1);
        for (int s = 4; s < cid_pkg::MAX_CIRCLES; s++)
            load(4'(s), pick_q(), pick_q(), pick_q(), 1'($urandom()));
        settle();
        write_reg(cid_pkg::REG_COUNT, 32'd16);
        write_reg(cid_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(cid_pkg::REG_ORIGIN_Y, 32'h8000_0000);
        evaluate(12'd0, 12'd0);
        evaluate(12'hFFF, 12'hFFF);
        settle();
        write_reg(cid_pkg::REG_COUNT, 32'd31);
        write_reg(cid_pkg::REG_SPACING_X, 32'h7FFF_FFFF);
        write_reg(cid_pkg::REG_SPACING_Y, 32'd1);
        evaluate(12'hFFF, 12'd0);
        evaluate(12'd5, 12'hFFF);
        settle();

        for (int ph = 0; ph < 9; ph++) begin
            calm = (ph == 4);
            case (ph % 3)
                0: begin sx = 32'd1; sy = 32'hFFFF_FFFF; end
                1: begin sx = 32'd65536; sy = 32'd32768; end
                default: begin sx = $urandom() | 1; sy = $urandom_range(1 << 20, 1); end
            endcase
            case (ph)
                0: cnt = 0;
                1: cnt = 16;
                2: cnt = 31;
                3: cnt = 2;
                default: cnt = $urandom_range(4, 1);
            endcase
            write_reg(cid_pkg::REG_ORIGIN_X, (ph < 2) ? 32'h8000_0000 : pick_q());
            write_reg(cid_pkg::REG_ORIGIN_Y, (ph < 2) ? 32'h7FFF_FFFF : pick_q());
            write_reg(cid_pkg::REG_SPACING_X, sx);
            write_reg(cid_pkg::REG_SPACING_Y, sy);
            write_reg(cid_pkg::REG_COUNT, cnt | ($urandom() & 32'hFFFF_FFE0));
            if (ph == 1) hold_left = 3000;
            for (int i = 0; i < 92; i++) begin
                if ($urandom_range(99) < 30)
                    load(4'($urandom()), pick_q(), pick_q(), pick_q(), 1'($urandom()));
                else
                    evaluate(12'($urandom()), 12'($urandom()));
            end
            settle();
        end

        if (board.errors + board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
